// ===== hw/rtl/acrls_pkg.sv =====
// Package for the converter channel level filter and scaler.
// Holds field widths, filter constants, register indexes and the pipeline word types.
// No dependencies.
package acrls_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CH_W       = 3;
    localparam int SCALED_W   = 19;
    localparam int BASE_W     = 13;
    localparam int CAL_W      = 11;
    localparam int FACTOR_W   = 14;
    localparam int PROD_W     = SAMPLE_W + FACTOR_W;
    localparam int CHANNELS_DEF = 4;
    localparam int CAL_REGS   = 4;
    localparam int CAL_IDX_W  = 2;

    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [2:0] REG_SCALE_BASE = 3'd0;
    localparam logic [2:0] REG_CAL_CH0    = 3'd1;
    localparam logic [2:0] REG_CAL_CH1    = 3'd2;
    localparam logic [2:0] REG_CAL_CH2    = 3'd3;
    localparam logic [2:0] REG_CAL_CH3    = 3'd4;

    localparam logic [BASE_W-1:0]   SCALE_BASE_RST = 13'd5000;
    localparam logic [SAMPLE_W:0]   RISE_GAP       = 13'd96;
    localparam logic [SAMPLE_W-1:0] RISE_STEP      = 12'd16;
    localparam logic [SAMPLE_W-1:0] ZERO_FLOOR     = 12'd8;

    // Division by 100 as a multiply by ceil(2^33 / 100) and a shift by 33.
    // The rounding error times the largest product stays below 2^33, so it is exact.
    localparam int RECIP_SHIFT = 33;
    localparam int RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP_DIV100 = 27'd85899346;
    localparam int QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;
    localparam logic [SCALED_W-1:0] SCALED_MAX = {SCALED_W{1'b1}};

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] lvl;
        logic [PROD_W-1:0]   prod;
    } t_prod_word;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] lvl;
        logic [SCALED_W-1:0] scaled;
    } t_out_word;

endpackage

// ===== hw/rtl/acrls_if.sv =====
// Valid/ready channel interfaces for sample words in and result words out.
// Depends on acrls_pkg for the field widths.
interface acrls_in_if import acrls_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]     channel;

    modport source (output valid, output sample, output channel, input ready);
    modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface acrls_out_if import acrls_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] level;
    logic [SCALED_W-1:0] scaled;

    modport source (output valid, output out_channel, output level, output scaled,
                    input ready);
    modport sink   (input valid, input out_channel, input level, input scaled,
                    output ready);
endinterface

// ===== hw/rtl/acrls_scaler.sv =====
// Divide-by-100 and saturation of the level-times-factor product.
// Depends on acrls_pkg for the word types and the reciprocal constant.
module acrls_scaler import acrls_pkg::*; (
    input  t_prod_word i_word,
    output t_out_word  o_word
);

    logic [PROD_W+RECIP_W-1:0] n_full;
    logic [QUOT_W-1:0]         n_quot;

    always_comb begin
        n_full = (PROD_W+RECIP_W)'(i_word.prod) * (PROD_W+RECIP_W)'(RECIP_DIV100);
        n_quot = n_full[PROD_W+RECIP_W-1:RECIP_SHIFT];
        o_word.ch  = i_word.ch;
        o_word.lvl = i_word.lvl;
        if (n_quot > QUOT_W'(SCALED_MAX)) begin
            o_word.scaled = SCALED_MAX;
        end else begin
            o_word.scaled = n_quot[SCALED_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/adc_channel_rise_limit_scale_top.sv =====
// An accepted word passes stage 1, stage 2 and the output register.
// Throughput: one word per cycle unless the output stalls; the level store is read on
// accept, written as stage 1 advances and forwarded to a following same-channel word.
// Reset (synchronous, active low) clears the level valid bits, so every level reads
// as zero, and loads scale_base with 5000 and all calibrations with zero.
module adc_channel_rise_limit_scale_top import acrls_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    acrls_in_if.sink            i_in,
    acrls_out_if.source         o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers.
    logic [BASE_W-1:0]        r_scale_base;
    logic signed [CAL_W-1:0]  r_cal [CAL_REGS];
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_base <= SCALE_BASE_RST;
            for (int i = 0; i < CAL_REGS; i++) begin
                r_cal[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCALE_BASE: r_scale_base <= pwdata[BASE_W-1:0];
                REG_CAL_CH0:    r_cal[0] <= pwdata[CAL_W-1:0];
                REG_CAL_CH1:    r_cal[1] <= pwdata[CAL_W-1:0];
                REG_CAL_CH2:    r_cal[2] <= pwdata[CAL_W-1:0];
                REG_CAL_CH3:    r_cal[3] <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SCALE_BASE: prdata = DATA_W'(r_scale_base);
            REG_CAL_CH0:    prdata = DATA_W'(unsigned'(r_cal[0]));
            REG_CAL_CH1:    prdata = DATA_W'(unsigned'(r_cal[1]));
            REG_CAL_CH2:    prdata = DATA_W'(unsigned'(r_cal[2]));
            REG_CAL_CH3:    prdata = DATA_W'(unsigned'(r_cal[3]));
            default:        prdata = '0;
        endcase
    end

    // Pipeline handshake.
    logic r_s1_v, r_s2_v, r_s3_v;
    logic s1_rdy, s2_rdy, s3_rdy;
    logic in_acc, in_range, s1_adv;

    assign s3_rdy    = !r_s3_v | o_out.ready;
    assign s2_rdy    = !r_s2_v | s3_rdy;
    assign s1_rdy    = !r_s1_v | s2_rdy;
    assign i_in.ready = s1_rdy;
    assign in_acc    = i_in.valid & s1_rdy;
    assign in_range  = i_in.channel < CH_W'(CHANNELS);
    assign s1_adv    = r_s1_v & s2_rdy;

    // Level store with per-entry valid bits; an entry never written reads as zero.
    logic [SAMPLE_W-1:0] r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    logic [SAMPLE_W-1:0] r_s1_rd;
    logic                r_s1_rd_vld;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [CH_W-1:0]     r_s1_ch;
    logic                r_fwd_vld;
    logic [CH_W-1:0]     r_fwd_ch;
    logic [SAMPLE_W-1:0] r_fwd_lvl;
    logic [AW-1:0]       rd_idx, wr_idx;

    assign rd_idx = i_in.channel[AW-1:0];
    assign wr_idx = r_s1_ch[AW-1:0];

    // Stage 1: level update and level-times-factor product.
    logic [SAMPLE_W-1:0]       n_old;
    logic [SAMPLE_W-1:0]       n_lvl;
    logic signed [CAL_W-1:0]   n_cal;
    logic signed [FACTOR_W:0]  n_sum;
    logic [FACTOR_W-1:0]       n_factor;
    logic [PROD_W-1:0]         n_prod;

    always_comb begin
        if (r_fwd_vld && (r_fwd_ch == r_s1_ch)) begin
            n_old = r_fwd_lvl;
        end else if (r_s1_rd_vld) begin
            n_old = r_s1_rd;
        end else begin
            n_old = '0;
        end
        if ({1'b0, r_s1_sample} > ({1'b0, n_old} + RISE_GAP)) begin
            n_lvl = n_old + RISE_STEP;
        end else begin
            n_lvl = r_s1_sample;
        end
        if (n_lvl < ZERO_FLOOR) begin
            n_lvl = '0;
        end
        // Channels without a calibration register use zero.
        if (r_s1_ch < CH_W'(CAL_REGS)) begin
            n_cal = r_cal[r_s1_ch[CAL_IDX_W-1:0]];
        end else begin
            n_cal = '0;
        end
        n_sum = signed'({2'b00, r_scale_base}) + (FACTOR_W+1)'(n_cal);
        if (n_sum < 0) begin
            n_factor = '0;
        end else begin
            n_factor = n_sum[FACTOR_W-1:0];
        end
        n_prod = PROD_W'(n_lvl) * PROD_W'(n_factor);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_range) begin
            r_s1_rd     <= r_mem[rd_idx];
            r_s1_rd_vld <= r_vld[rd_idx];
            r_s1_sample <= i_in.sample;
            r_s1_ch     <= i_in.channel;
        end
        if (s1_adv) begin
            r_mem[wr_idx] <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
        end else if (s1_adv) begin
            r_vld[wr_idx] <= 1'b1;
            r_fwd_vld     <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_fwd_ch  <= r_s1_ch;
            r_fwd_lvl <= n_lvl;
        end
    end

    // Stage 2 holds the product; stage 3 is the output register.
    t_prod_word r_s2;
    t_out_word  n_s3;
    t_out_word  r_s3;

    acrls_scaler u_scaler (
        .i_word (r_s2),
        .o_word (n_s3)
    );

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2.ch   <= r_s1_ch;
            r_s2.lvl  <= n_lvl;
            r_s2.prod <= n_prod;
        end
        if (r_s2_v && s3_rdy) begin
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_v <= in_acc & in_range;
            end
            if (s2_rdy) begin
                r_s2_v <= r_s1_v;
            end
            if (s3_rdy) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    assign o_out.valid       = r_s3_v;
    assign o_out.out_channel = r_s3.ch;
    assign o_out.level       = r_s3.lvl;
    assign o_out.scaled      = r_s3.scaled;

endmodule

// ===== hw/rtl/acrls_checker.sv =====
// Port-level checks on the result channel of the level filter and scaler,
// with the bind that attaches them to the top level. Depends on acrls_pkg.
module acrls_port_checks import acrls_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [CH_W-1:0]     i_out_channel,
    input logic [SAMPLE_W-1:0] i_level,
    input logic [SCALED_W-1:0] i_scaled
);

    // A stalled word holds until it is taken.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_channel) && $stable(i_level)
        && $stable(i_scaled))
        else $error("result word changed while stalled");

    // Words arrive only for channels that exist.
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_out_channel < CH_W'(CHANNELS)))
        else $error("result for a channel out of range");

    // Levels below the floor are forced to zero.
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_level < ZERO_FLOOR) |-> (i_level == '0))
        else $error("level below floor not cleared");

    // A zero level scales to zero.
    a_zero_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_level == '0) |-> (i_scaled == '0))
        else $error("zero level with nonzero scaled value");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result word present after reset");

endmodule

bind adc_channel_rise_limit_scale_top acrls_port_checks #(.CHANNELS(CHANNELS))
    u_acrls_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_out_channel (o_out.out_channel),
    .i_level       (o_out.level),
    .i_scaled      (o_out.scaled)
);

// ===== tb/sv/acrls_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the converter channel level filter and scaler.
// Snoops the register port and both word channels, predicts every result word and
// compares it with the block's output. Depends on acrls_pkg.
module acrls_checker import acrls_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [SAMPLE_W-1:0] i_in_sample,
    input  logic [CH_W-1:0]     i_in_channel,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [CH_W-1:0]     i_out_channel,
    input  logic [SAMPLE_W-1:0] i_out_level,
    input  logic [SCALED_W-1:0] i_out_scaled,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [DATA_W-1:0]   i_pwdata,
    output int                  o_mismatches,
    output int                  o_pending,
    output int                  o_results
);

    localparam int SCALE_DIV = 100;

    logic [BASE_W-1:0]       scale_base_q;
    logic signed [CAL_W-1:0] cal_q [CAL_REGS];
    logic [SAMPLE_W-1:0]     level_q [CHANNELS];
    t_out_word               expected_words [$];
    int                      mismatch_count = 0;
    int                      pending_count = 0;
    int                      result_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;
    assign o_results    = result_count;

    function automatic t_out_word filter_and_scale(input logic [SAMPLE_W-1:0] sample,
                                                   input logic [CH_W-1:0]     ch,
                                                   input logic [SAMPLE_W-1:0] prev_level);
        t_out_word w;
        int        factor;
        longint    quot;
        w.ch = ch;
        // A jump of more than the rise gap only moves the level up by one step.
        if (int'(sample) > int'(prev_level) + int'(RISE_GAP))
            w.lvl = prev_level + RISE_STEP;
        else
            w.lvl = sample;
        if (w.lvl < ZERO_FLOOR) begin
            w.lvl    = '0;
            w.scaled = '0;
        end else begin
            factor = int'(scale_base_q) + ((ch < CAL_REGS) ? int'(cal_q[ch]) : 0);
            if (factor < 0)
                factor = 0;
            quot = (longint'(w.lvl) * longint'(factor)) / SCALE_DIV;
            w.scaled = (quot > longint'(SCALED_MAX)) ? SCALED_MAX : quot[SCALED_W-1:0];
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            scale_base_q <= SCALE_BASE_RST;
            for (int i = 0; i < CAL_REGS; i++)
                cal_q[i] <= '0;
            for (int i = 0; i < CHANNELS; i++)
                level_q[i] <= '0;
            expected_words.delete();
            pending_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing predicted: channel %0d level %0d scaled %0d",
                           i_out_channel, i_out_level, i_out_scaled);
                    errs++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_channel !== want.ch) begin
                        $error("out_channel: expected %0d, actual %0d", want.ch, i_out_channel);
                        errs++;
                    end
                    if (i_out_level !== want.lvl) begin
                        $error("level: expected %0d, actual %0d", want.lvl, i_out_level);
                        errs++;
                    end
                    if (i_out_scaled !== want.scaled) begin
                        $error("scaled: expected %0d, actual %0d", want.scaled, i_out_scaled);
                        errs++;
                    end
                end
                result_count <= result_count + 1;
            end
            // Words for channels past the configured count are dropped without a trace.
            if (i_in_valid && i_in_ready && i_in_channel < CHANNELS) begin
                want = filter_and_scale(i_in_sample, i_in_channel, level_q[i_in_channel]);
                level_q[i_in_channel] <= want.lvl;
                expected_words.push_back(want);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_SCALE_BASE: scale_base_q <= i_pwdata[BASE_W-1:0];
                    REG_CAL_CH0:    cal_q[0] <= i_pwdata[CAL_W-1:0];
                    REG_CAL_CH1:    cal_q[1] <= i_pwdata[CAL_W-1:0];
                    REG_CAL_CH2:    cal_q[2] <= i_pwdata[CAL_W-1:0];
                    REG_CAL_CH3:    cal_q[3] <= i_pwdata[CAL_W-1:0];
                    default: ;
                endcase
            end
            pending_count <= expected_words.size();
        end
        mismatch_count <= mismatch_count + errs;
    end

endmodule

// ===== tb/sv/tb_adc_channel_rise_limit_scale_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the converter channel level filter and scaler.
// Drives sample words and register writes, throttles the result channel and gives the
// verdict from the counts of acrls_checker. Depends on acrls_pkg and acrls_if.
module tb_adc_channel_rise_limit_scale_top;
    import acrls_pkg::*;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 135;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic hold_req = 1'b0;
    logic gapless = 1'b0;
    int   burst_left = 0;
    int   offered_words = 0;
    int   ignored_words = 0;
    int   setting_count = 0;
    int   cycle_count = 0;
    int   sample_cursor [CHANNELS_DEF];
    int   mismatches;
    int   pending_words;
    int   results_seen;

    acrls_in_if  in_ch ();
    acrls_out_if out_ch ();

    adc_channel_rise_limit_scale_top #(.CHANNELS(CHANNELS_DEF)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    acrls_checker #(.CHANNELS(CHANNELS_DEF)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_sample   (in_ch.sample),
        .i_in_channel  (in_ch.channel),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_channel (out_ch.out_channel),
        .i_out_level   (out_ch.level),
        .i_out_scaled  (out_ch.scaled),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending_words),
        .o_results     (results_seen)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: a rotating stall pattern, with one long hold-off on request.
    initial begin
        int rx_cycle;
        bit hold_taken;
        rx_cycle = 0;
        hold_taken = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case ((rx_cycle / 300) % 4)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (rx_cycle % 5) != 0;
                endcase
            end
        end
    end

    // Puts random bits above the register field so that decoding must ignore them.
    function automatic logic [DATA_W-1:0] with_noise(input int value, input int width);
        return ($urandom() << width) | (value & ((1 << width) - 1));
    endfunction

    task automatic write_reg(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int k);
        int base;
        int cal [CAL_REGS];
        case (k)
            0: begin
                base = 8191;
                cal = '{1023, -1024, 1023, -1};
            end
            1: begin
                base = 0;
                cal = '{-1024, 1023, -1, 0};
            end
            2: begin
                // Factor of exactly zero on channel 0, just positive on channel 1.
                base = 1024;
                cal = '{-1024, -1023, 0, 1023};
            end
            default: begin
                base = $urandom_range(0, 8191);
                foreach (cal[i])
                    cal[i] = int'($urandom_range(0, 2047)) - 1024;
            end
        endcase
        write_reg(REG_SCALE_BASE, with_noise(base, BASE_W));
        write_reg(REG_CAL_CH0, with_noise(cal[0], CAL_W));
        write_reg(REG_CAL_CH1, with_noise(cal[1], CAL_W));
        write_reg(REG_CAL_CH2, with_noise(cal[2], CAL_W));
        write_reg(REG_CAL_CH3, with_noise(cal[3], CAL_W));
        // Writes past the last register must leave everything unchanged.
        if (k == 2 || $urandom_range(0, 3) == 0) begin
            for (int idx = REG_CAL_CH3 + 1; idx < (1 << (ADDR_W - 2)); idx++)
                write_reg(idx[ADDR_W-3:0], $urandom());
        end
        setting_count++;
    endtask

    task automatic offer_word(input int s, input int ch);
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s[SAMPLE_W-1:0];
        in_ch.channel <= ch[CH_W-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        offered_words++;
        if (ch >= CHANNELS_DEF)
            ignored_words++;
        if (burst_left > 0) begin
            burst_left--;
        end else if (!gapless) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Stops the sender and waits until every predicted word has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        // Words on unused channels are dropped at the input and never enter the pipeline.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int n_words);
        int done;
        int ch;
        int len;
        int mode;
        int s;
        done = 0;
        while (done < n_words) begin
            if ($urandom_range(0, 3) != 0) begin
                // A run of related samples on one channel, so that levels track and climb.
                ch   = $urandom_range(0, CHANNELS_DEF - 1);
                len  = $urandom_range(3, 16);
                mode = $urandom_range(0, 3);
                repeat (len) begin
                    case (mode)
                        0: s = sample_cursor[ch] + (($urandom_range(0, 7) == 0) ?
                               $urandom_range(97, 200) : $urandom_range(0, 96));
                        1: s = sample_cursor[ch] - int'($urandom_range(0, 100));
                        2: s = $urandom_range(0, 15);
                        default: s = sample_cursor[ch] + int'($urandom_range(0, 8)) - 4;
                    endcase
                    if (s < 0)
                        s = 0;
                    if (s > SAMPLE_MAX)
                        s = SAMPLE_MAX;
                    sample_cursor[ch] = s;
                    offer_word(s, ch);
                    done++;
                end
            end else begin
                ch = $urandom_range(0, (1 << CH_W) - 1);
                offer_word($urandom_range(0, SAMPLE_MAX), ch);
                if (ch < CHANNELS_DEF)
                    done++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        in_ch.channel = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset settings, back to back to exercise forwarding.
        gapless = 1'b1;
        offer_word(0, 0);
        offer_word(7, 0);
        offer_word(8, 0);
        offer_word(104, 0);
        offer_word(201, 0);
        offer_word(4095, 0);
        offer_word(4095, 1);
        offer_word(4095, 1);
        offer_word(128, 1);
        offer_word(0, 1);
        offer_word(97, 2);
        offer_word(112, 2);
        offer_word(50, 3);
        offer_word(51, 3);
        offer_word(4095, 3);
        offer_word(4095, 4);
        offer_word(0, 5);
        offer_word(4095, 6);
        offer_word(2730, 7);
        offer_word(1365, 0);
        offer_word(2730, 2);
        gapless = 1'b0;
        wait_drained();

        for (int k = 0; k < PHASES; k++) begin
            apply_setting(k);
            if (k == 3)
                hold_req <= 1'b1;
            gapless = (k == 3 || k == 6);
            run_random(WORDS_PER_PHASE / 2);
            if (k == 5)
                wait_drained();
            run_random(WORDS_PER_PHASE - WORDS_PER_PHASE / 2);
            wait_drained();
        end

        $display("Sent %0d sample words, %0d of them on unused channels, under %0d settings.",
                 offered_words, ignored_words, setting_count + 1);
        $display("Checked %0d result words with %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
